>>> design/lz10_pkg.sv
// ----------------------------------------------------------------------------
// lz10 package
// Shared transfer types, status codes and header constants of the LZ77 type
// 0x10 stream decompressor.
// ----------------------------------------------------------------------------
package lz10_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       run_last;
   } rsp_type;

   localparam logic [2:0] STATUS_DATA       = 3'd0;
   localparam logic [2:0] STATUS_OK         = 3'd1;
   localparam logic [2:0] STATUS_BAD_HEADER = 3'd2;
   localparam logic [2:0] STATUS_BAD_LENGTH = 3'd3;
   localparam logic [2:0] STATUS_TOO_FAR    = 3'd4;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd5;

   localparam logic [7:0]  TYPE_BYTE        = 8'h10;
   localparam logic [4:0]  RUN_BIAS         = 5'd3;
   localparam logic [24:0] MAX_LENGTH_RESET = 25'd16777216;

   // "LZ77" followed by the type byte
   function automatic logic [7:0] magic_byte(input logic [2:0] pos);
      logic [7:0] value;
      case (pos)
         3'd0: value = 8'h4C;
         3'd1: value = 8'h5A;
         3'd2: value = 8'h37;
         3'd3: value = 8'h37;
         default: value = TYPE_BYTE;
      endcase
      return value;
   endfunction

endpackage

>>> design/lz10_ram.sv
// ----------------------------------------------------------------------------
// lz10 generic RAM
// Simple dual-port memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lz10_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lz10_core.sv
// ----------------------------------------------------------------------------
// lz10 decode core
// Header check, flag/literal/pair decode and the match copy sequencer that
// walks the history memory one byte at a time.
// ----------------------------------------------------------------------------
module lz10_core #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lz10_pkg::req_type req_data,
   input  logic [24:0]       max_len,
   input  logic              res_ready,
   output logic              res_valid,
   output lz10_pkg::rsp_type res_data
);
   import lz10_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(WINDOW_DEPTH);
   localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_DEPTH - 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_LIT    = 6'b000100,
      S_READ   = 6'b001000,
      S_COPY   = 6'b010000,
      S_TAIL   = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      PH_HEADER   = 4'b0001,
      PH_BODY     = 4'b0010,
      PH_PAIR_LOW = 4'b0100,
      PH_DONE     = 4'b1000
   } phase_type;

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [2:0]    hdr_pos_ff, hdr_pos_in;
   logic [23:0]   target_ff, target_in;
   logic [24:0]   produced_ff, produced_in;
   logic [7:0]    flag_ff, flag_in;
   logic [3:0]    bit_pos_ff, bit_pos_in;
   logic [7:0]    pair_high_ff, pair_high_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic          pend_valid_ff, pend_valid_in;

   logic [7:0]    byte_ff, byte_in;
   logic          last_ff, last_in;
   logic [2:0]    pend_status_ff, pend_status_in;
   logic [4:0]    count_ff, count_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;

   logic [23:0]   tgt_new;
   logic          len_bad;
   logic [3:0]    bit_pos_dec;
   logic [4:0]    run_count;
   logic [12:0]   distance;
   logic          too_far;
   logic [AW:0]   wr_ext, dist_ext, src_diff, src_wrap;
   logic [AW-1:0] copy_src;
   logic [24:0]   produced_next;
   logic [24:0]   target_ext;
   logic          hits_target;
   logic [AW-1:0] wr_ptr_next, rd_ptr_next;
   logic          ram_we;
   logic [7:0]    ram_rdata;
   logic          entry_end;

   // length bytes arrive little-endian
   always_comb begin
      tgt_new = target_ff;
      case (hdr_pos_ff)
         3'd5: tgt_new[7:0]   = byte_ff;
         3'd6: tgt_new[15:8]  = byte_ff;
         3'd7: tgt_new[23:16] = byte_ff;
         default: tgt_new = target_ff;
      endcase
   end

   assign len_bad     = (tgt_new == 24'd0) || ({1'b0, tgt_new} > max_len);
   assign bit_pos_dec = bit_pos_ff - 4'd1;
   assign run_count   = {1'b0, pair_high_ff[7:4]} + RUN_BIAS;
   assign distance    = {1'b0, pair_high_ff[3:0], byte_ff} + 13'd1;
   assign too_far     = {12'd0, distance} > produced_ff;

   // copy source is the write pointer stepped back by the distance, modulo the window
   assign wr_ext   = {1'b0, wr_ptr_ff};
   assign dist_ext = (AW+1)'(distance);
   assign src_diff = wr_ext - dist_ext;
   assign src_wrap = src_diff + DEPTH_EXT;
   assign copy_src = (wr_ext >= dist_ext) ? src_diff[AW-1:0] : src_wrap[AW-1:0];

   assign produced_next = produced_ff + 25'd1;
   assign target_ext    = {1'b0, target_ff};
   assign hits_target   = (produced_next == target_ext);
   assign wr_ptr_next   = (wr_ptr_ff == ADDR_LAST) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_ptr_next   = (rd_ptr_ff == ADDR_LAST) ? '0 : rd_ptr_ff + AW'(1);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      hdr_pos_in     = hdr_pos_ff;
      target_in      = target_ff;
      produced_in    = produced_ff;
      flag_in        = flag_ff;
      bit_pos_in     = bit_pos_ff;
      pair_high_in   = pair_high_ff;
      wr_ptr_in      = wr_ptr_ff;
      pend_valid_in  = pend_valid_ff;
      byte_in        = byte_ff;
      last_in        = last_ff;
      pend_status_in = pend_status_ff;
      count_in       = count_ff;
      rd_ptr_in      = rd_ptr_ff;
      ram_we         = 1'b0;
      res_valid      = 1'b0;
      res_data       = '0;
      entry_end      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in  = req_data.in_byte;
               last_in  = req_data.in_last;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            pend_valid_in = 1'b0;
            case (phase_ff)
               PH_HEADER: begin
                  if (hdr_pos_ff < 3'd5 && byte_ff != magic_byte(hdr_pos_ff)) begin
                     pend_valid_in  = 1'b1;
                     pend_status_in = STATUS_BAD_HEADER;
                     state_in       = S_TAIL;
                  end else begin
                     target_in = tgt_new;
                     if (hdr_pos_ff == 3'd7 && len_bad) begin
                        pend_valid_in  = 1'b1;
                        pend_status_in = STATUS_BAD_LENGTH;
                        state_in       = S_TAIL;
                     end else begin
                        if (hdr_pos_ff == 3'd7) begin
                           phase_in    = PH_BODY;
                           bit_pos_in  = 4'd0;
                           produced_in = '0;
                           wr_ptr_in   = '0;
                        end else begin
                           hdr_pos_in = hdr_pos_ff + 3'd1;
                        end
                        if (last_ff) begin
                           pend_valid_in  = 1'b1;
                           pend_status_in = STATUS_TRUNCATED;
                           state_in       = S_TAIL;
                        end else begin
                           state_in = S_IDLE;
                        end
                     end
                  end
               end
               PH_BODY: begin
                  if (bit_pos_ff == 4'd0) begin
                     flag_in    = byte_ff;
                     bit_pos_in = 4'd8;
                     state_in   = S_TAIL;
                  end else begin
                     bit_pos_in = bit_pos_dec;
                     if (!flag_ff[bit_pos_dec[2:0]]) begin
                        state_in = S_LIT;
                     end else begin
                        pair_high_in = byte_ff;
                        phase_in     = PH_PAIR_LOW;
                        state_in     = S_TAIL;
                     end
                  end
               end
               PH_PAIR_LOW: begin
                  if (too_far) begin
                     pend_valid_in  = 1'b1;
                     pend_status_in = STATUS_TOO_FAR;
                     state_in       = S_TAIL;
                  end else begin
                     phase_in  = PH_BODY;
                     count_in  = run_count;
                     rd_ptr_in = copy_src;
                     state_in  = S_READ;
                  end
               end
               PH_DONE: begin
                  entry_end = last_ff;
                  state_in  = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_LIT: begin
            res_valid         = 1'b1;
            res_data.out_byte = byte_ff;
            res_data.status   = STATUS_DATA;
            res_data.run_last = !hits_target && !last_ff;
            if (res_ready) begin
               ram_we      = 1'b1;
               produced_in = produced_next;
               wr_ptr_in   = wr_ptr_next;
               state_in    = S_TAIL;
            end
         end

         // history read data lands in the read register here
         S_READ: begin
            state_in = S_COPY;
         end

         S_COPY: begin
            res_valid         = 1'b1;
            res_data.out_byte = ram_rdata;
            res_data.status   = STATUS_DATA;
            res_data.run_last = (count_ff == 5'd1) && !hits_target && !last_ff;
            if (res_ready) begin
               ram_we      = 1'b1;
               produced_in = produced_next;
               wr_ptr_in   = wr_ptr_next;
               rd_ptr_in   = rd_ptr_next;
               count_in    = count_ff - 5'd1;
               if (count_ff == 5'd1 || hits_target) begin
                  state_in = S_TAIL;
               end else begin
                  state_in = S_READ;
               end
            end
         end

         S_TAIL: begin
            if (pend_valid_ff) begin
               res_valid       = 1'b1;
               res_data.status = pend_status_ff;
            end else if (produced_ff >= target_ext) begin
               res_valid       = 1'b1;
               res_data.status = STATUS_OK;
            end else if (last_ff) begin
               res_valid       = 1'b1;
               res_data.status = STATUS_TRUNCATED;
            end
            res_data.run_last = 1'b1;
            if (!res_valid) begin
               state_in = S_IDLE;
            end else if (res_ready) begin
               pend_valid_in = 1'b0;
               entry_end     = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of entry: rearm on a last byte, otherwise swallow the rest
      if (entry_end) begin
         if (last_ff) begin
            phase_in     = PH_HEADER;
            hdr_pos_in   = '0;
            target_in    = '0;
            produced_in  = '0;
            flag_in      = '0;
            bit_pos_in   = '0;
            pair_high_in = '0;
            wr_ptr_in    = '0;
         end else begin
            phase_in = PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_HEADER;
         hdr_pos_ff    <= '0;
         target_ff     <= '0;
         produced_ff   <= '0;
         flag_ff       <= '0;
         bit_pos_ff    <= '0;
         pair_high_ff  <= '0;
         wr_ptr_ff     <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         hdr_pos_ff    <= hdr_pos_in;
         target_ff     <= target_in;
         produced_ff   <= produced_in;
         flag_ff       <= flag_in;
         bit_pos_ff    <= bit_pos_in;
         pair_high_ff  <= pair_high_in;
         wr_ptr_ff     <= wr_ptr_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      last_ff        <= last_in;
      pend_status_ff <= pend_status_in;
      count_ff       <= count_in;
      rd_ptr_ff      <= rd_ptr_in;
   end

   lz10_ram #(
      .WIDTH(8),
      .DEPTH(WINDOW_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (res_data.out_byte),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

endmodule

>>> design/lz10_stream_decompressor_unit.sv
// flow: a transfer is registered in IDLE and decoded in the next cycle; its results then pass
//   through the LIT, READ and COPY, or TAIL state into the output register, held by rsp_stall
// input: a byte is taken only in IDLE, after the last one is fully handled; a match copies
//   one byte per pass through READ and COPY (registered read)
// reset: synchronous, clears the decoder to the header phase and the length limit to 2^24;
//   history contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// lz10 stream decompressor unit
// Top level: length limit register, decode core and the result output register.
// ----------------------------------------------------------------------------
module lz10_stream_decompressor_unit #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lz10_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lz10_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [24:0]       csr_write_data
);
   import lz10_pkg::*;

   logic [24:0] max_len_ff, max_len_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        res_valid;
   rsp_type     res_data;

   // the output register takes a new result when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      max_len_in   = csr_write_enable ? csr_write_data : max_len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lz10_core #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .max_len   (max_len_ff),
      .res_ready (out_free),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

endmodule

>>> sim/lz10_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz10 result checker
// Watches both channels and the limit register port of the decompressor,
// decodes every accepted input byte itself and compares each result transfer
// field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module lz10_result_checker #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lz10_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lz10_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [24:0]       csr_write_data,
   output int                mismatch_count,
   output int                results_checked,
   output int                results_pending
);

   typedef enum logic [1:0] {
      STAGE_HEADER,
      STAGE_FLAGS,
      STAGE_PAIR_LOW,
      STAGE_ENDED
   } stage_type;

   // "LZ77" then the type byte, first byte in the top lane
   localparam logic [39:0] HEADER_TAG = {8'h4C, 8'h5A, 8'h37, 8'h37, lz10_pkg::TYPE_BYTE};

   logic [7:0]        window_mem [WINDOW_DEPTH];
   stage_type         stage;
   logic [2:0]        header_pos;
   logic [23:0]       declared_length;
   logic [24:0]       bytes_made;
   logic [7:0]        flag_byte;
   logic [3:0]        flags_left;
   logic [7:0]        pair_high;
   logic [24:0]       length_limit;
   lz10_pkg::rsp_type expected_q [$];
   lz10_pkg::rsp_type newest;
   lz10_pkg::rsp_type oldest;
   bit                newest_held;

   function automatic void restart_entry();
      stage           = STAGE_HEADER;
      header_pos      = '0;
      declared_length = '0;
      bytes_made      = '0;
      flag_byte       = '0;
      flags_left      = '0;
      pair_high       = '0;
   endfunction

   function automatic void close_entry(input logic last);
      if (last) begin
         restart_entry();
      end else begin
         stage = STAGE_ENDED;
      end
   endfunction

   // the newest result is held back so that run_last can be set on it
   function automatic void note_result(input logic [7:0] value, input logic [2:0] code);
      if (newest_held) begin
         expected_q.push_back(newest);
      end
      newest      = '{out_byte: value, status: code, run_last: 1'b0};
      newest_held = 1'b1;
   endfunction

   function automatic void emit_data(input logic [7:0] value);
      window_mem[int'(bytes_made) % WINDOW_DEPTH] = value;
      bytes_made = bytes_made + 25'd1;
      note_result(value, lz10_pkg::STATUS_DATA);
   endfunction

   task automatic decode_transfer(input lz10_pkg::req_type item);
      int          pos;
      int          run_len;
      int          distance;
      int          k;
      logic [15:0] word;
      case (stage)
         STAGE_HEADER: begin
            pos = int'(header_pos);
            if (pos < 5) begin
               if (item.in_byte != HEADER_TAG[8 * (4 - pos) +: 8]) begin
                  note_result(8'h00, lz10_pkg::STATUS_BAD_HEADER);
                  close_entry(item.in_last);
                  return;
               end
            end else begin
               declared_length = declared_length | (24'(item.in_byte) << (8 * (pos - 5)));
            end
            if (pos == 7) begin
               if (declared_length == 24'd0 || {1'b0, declared_length} > length_limit) begin
                  note_result(8'h00, lz10_pkg::STATUS_BAD_LENGTH);
                  close_entry(item.in_last);
                  return;
               end
               stage      = STAGE_FLAGS;
               flags_left = '0;
               bytes_made = '0;
            end else begin
               header_pos = 3'(pos + 1);
            end
            if (item.in_last) begin
               note_result(8'h00, lz10_pkg::STATUS_TRUNCATED);
               restart_entry();
            end
            return;
         end
         STAGE_FLAGS: begin
            if (flags_left == 4'd0) begin
               flag_byte  = item.in_byte;
               flags_left = 4'd8;
            end else begin
               flags_left = flags_left - 4'd1;
               if (!flag_byte[flags_left[2:0]]) begin
                  emit_data(item.in_byte);
               end else begin
                  pair_high = item.in_byte;
                  stage     = STAGE_PAIR_LOW;
               end
            end
         end
         STAGE_PAIR_LOW: begin
            word     = {pair_high, item.in_byte};
            run_len  = int'(word[15:12]) + 3;
            distance = int'(word[11:0]) + 1;
            if (distance > int'(bytes_made)) begin
               note_result(8'h00, lz10_pkg::STATUS_TOO_FAR);
               close_entry(item.in_last);
               return;
            end
            // the run is cut short at the declared length
            for (k = 0; k < run_len && bytes_made < {1'b0, declared_length}; k++) begin
               emit_data(window_mem[(int'(bytes_made) - distance) % WINDOW_DEPTH]);
            end
            stage = STAGE_FLAGS;
         end
         default: begin
            if (item.in_last) begin
               restart_entry();
            end
            return;
         end
      endcase
      if (bytes_made >= {1'b0, declared_length}) begin
         note_result(8'h00, lz10_pkg::STATUS_OK);
         close_entry(item.in_last);
      end else if (item.in_last) begin
         note_result(8'h00, lz10_pkg::STATUS_TRUNCATED);
         restart_entry();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_entry();
         length_limit = lz10_pkg::MAX_LENGTH_RESET;
         expected_q.delete();
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing expected: out_byte %02h status %0d run_last %0b",
                      rsp_data.out_byte, rsp_data.status, rsp_data.run_last);
               mismatch_count++;
            end else begin
               oldest = expected_q.pop_front();
               if (rsp_data.out_byte !== oldest.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", oldest.out_byte, rsp_data.out_byte);
                  mismatch_count++;
               end
               if (rsp_data.status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.run_last !== oldest.run_last) begin
                  $error("run_last: expected %0b, got %0b", oldest.run_last, rsp_data.run_last);
                  mismatch_count++;
               end
               results_checked++;
            end
         end
         if (csr_write_enable) begin
            length_limit = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            newest_held = 1'b0;
            decode_transfer(req_data);
            if (newest_held) begin
               newest.run_last = 1'b1;
               expected_q.push_back(newest);
            end
         end
      end
      results_pending = expected_q.size();
   end

endmodule

>>> sim/tb_lz10_stream_decompressor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz10 stream decompressor unit testbench
// Feeds compressed entries byte by byte: a few hand-made entries for the header,
// length, distance, truncation and completion cases, then random well-formed
// and broken entries under changing length limits. Random gaps and stalls on
// both channels; the checker module predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_lz10_stream_decompressor_unit;

   localparam int RANDOM_ITEMS   = 380;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LIMIT_MAX      = 16777216;
   localparam int LENGTH_FIELD   = 16777215;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   lz10_pkg::req_type req_data         = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   lz10_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [24:0]       csr_write_data   = '0;

   int         mismatch_count;
   int         results_checked;
   int         results_pending;
   logic [7:0] byte_q [$];
   int         limit_setting = LIMIT_MAX;
   int         random_items_sent;
   int         transfers_sent;
   int         entries_sent;
   int         limit_writes;
   int         quiet_cycles;
   int         stall_run;
   bit         sender_quiet;
   bit         receiver_quiet;

   lz10_stream_decompressor_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lz10_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .results_checked  (results_checked),
      .results_pending  (results_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure: mostly free, short stalls, now and then a long one
   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run = stall_run - 1;
         rsp_stall <= 1'b1;
      end else if (receiver_quiet || $urandom_range(0, 99) < 60) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("** lz10_stream_decompressor_unit: FAILED **");
         $finish;
      end
   end

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_quiet || roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_limit();
      case ($urandom_range(0, 4))
         0:       return 1;
         1:       return LIMIT_MAX;
         2:       return $urandom_range(2, 64);
         3:       return $urandom_range(65, 5000);
         default: return LENGTH_FIELD;
      endcase
   endfunction

   // the final byte of the queue carries in_last
   task automatic send_entry();
      int i;
      int gap;
      for (i = 0; i < byte_q.size(); i++) begin
         gap = gap_length();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= '{in_byte: byte_q[i], in_last: (i == byte_q.size() - 1)};
         do @(posedge clock); while (req_stall);
         transfers_sent++;
      end
      entries_sent++;
   endtask

   // hold off the sender until every expected result has arrived
   task automatic settle_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input int value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= 25'(value);
      limit_setting = value;
      limit_writes++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_header(input int len, input int bad_pos);
      logic [7:0]  tag;
      logic [23:0] field;
      int          p;
      for (p = 0; p < 5; p++) begin
         tag = lz10_pkg::magic_byte(3'(p));
         if (p == bad_pos) begin
            tag = tag ^ 8'($urandom_range(1, 255));
         end
         byte_q.push_back(tag);
      end
      field = 24'(len);
      byte_q.push_back(field[7:0]);
      byte_q.push_back(field[15:8]);
      byte_q.push_back(field[23:16]);
   endtask

   // flag groups of literals and back-references that reach the target length, unless far is
   // set: then the first reference points past the bytes made so far and ends the body
   task automatic build_body(input int target, input int match_pct, input bit long_runs,
                             input bit far);
      int          made;
      int          bitn;
      int          distance;
      int          cnt;
      int          reach;
      bit          stop;
      logic [7:0]  flag;
      logic [15:0] word;
      logic [7:0]  toks [$];
      made = 0;
      stop = 1'b0;
      while (made < target && !stop) begin
         toks.delete();
         flag = 8'($urandom);
         for (bitn = 7; bitn >= 0 && made < target && !stop; bitn--) begin
            if ((made > 0 && $urandom_range(0, 99) < match_pct) ||
                (far && $urandom_range(0, 7) == 0)) begin
               flag[bitn] = 1'b1;
               cnt = long_runs ? 15 : $urandom_range(0, 15);
               reach = (made < 4096) ? made : 4096;
               if (far) begin
                  distance = made + $urandom_range(1, 8);
                  if (distance > 4096) begin
                     distance = 4096;
                  end
                  stop = 1'b1;
               end else begin
                  distance = ($urandom_range(0, 4) == 0) ? reach : $urandom_range(1, reach);
               end
               word = {4'(cnt), 12'(distance - 1)};
               toks.push_back(word[15:8]);
               toks.push_back(word[7:0]);
               made += cnt + 3;
            end else begin
               flag[bitn] = 1'b0;
               toks.push_back(8'($urandom));
               made++;
            end
         end
         byte_q.push_back(flag);
         foreach (toks[i]) begin
            byte_q.push_back(toks[i]);
         end
      end
   endtask

   task automatic build_random_entry();
      int kind;
      int len;
      int hi;
      int bad_pos;
      int n;
      int k;
      bit far;
      byte_q.delete();
      kind    = $urandom_range(0, 99);
      bad_pos = -1;
      far     = 1'b0;
      if (kind < 8) begin
         // noise that fails in the header, often on the first byte
         n = $urandom_range(1, 5);
         for (k = 0; k < n; k++) begin
            byte_q.push_back((k == 0 && $urandom_range(0, 1) == 1) ? 8'h4C : 8'($urandom));
         end
      end else begin
         hi = ($urandom_range(0, 9) == 0) ? 250 : 40;
         if (hi > limit_setting) begin
            hi = limit_setting;
         end
         len = $urandom_range(1, hi);
         if (kind < 14) begin
            len = 0;
         end else if (kind < 20) begin
            if (limit_setting >= LENGTH_FIELD) begin
               len = 0;
            end else begin
               len = limit_setting + $urandom_range(1, 50);
               if (len > LENGTH_FIELD) begin
                  len = LENGTH_FIELD;
               end
            end
         end else if (kind < 25) begin
            bad_pos = $urandom_range(0, 4);
         end else if (kind < 33) begin
            far = 1'b1;
         end
         add_header(len, bad_pos);
         if (kind >= 25) begin
            build_body(len, $urandom_range(10, 70), 1'b0, far);
         end
      end
      random_items_sent += byte_q.size();
      if ($urandom_range(0, 99) < 15) begin
         // cut the entry short, possibly inside the header
         n = $urandom_range(1, byte_q.size());
         while (byte_q.size() > n) begin
            void'(byte_q.pop_back());
         end
      end else if ($urandom_range(0, 99) < 35) begin
         // trailing bytes after the end of the entry are ignored
         n = $urandom_range(1, 3);
         for (k = 0; k < n; k++) begin
            byte_q.push_back(8'($urandom));
         end
      end
   endtask

   initial begin
      int  phase_entries;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // bad first byte, an ignored byte, then the last byte rearms
      byte_q = '{8'hFF, 8'h00, 8'h55};
      send_entry();
      // header cut short while still matching
      byte_q = '{8'h4C, 8'h5A};
      send_entry();
      // largest declared length under the reset limit, one literal, then truncated
      byte_q.delete();
      add_header(LENGTH_FIELD, -1);
      byte_q.push_back(8'h00);
      byte_q.push_back(8'hFF);
      send_entry();

      settle_block();
      write_limit(1);
      // length above the limit
      byte_q.delete();
      add_header(2, -1);
      send_entry();
      // reference before any byte has been made
      byte_q.delete();
      add_header(1, -1);
      byte_q.push_back(8'h80);
      byte_q.push_back(8'h00);
      byte_q.push_back(8'h00);
      send_entry();
      // one literal reaches the length
      byte_q.delete();
      add_header(1, -1);
      byte_q.push_back(8'h00);
      byte_q.push_back(8'h00);
      send_entry();

      settle_block();
      write_limit(LIMIT_MAX);
      phase_entries = 0;
      while (random_items_sent < RANDOM_ITEMS) begin
         sender_quiet   = ($urandom_range(0, 3) == 0);
         receiver_quiet = ($urandom_range(0, 3) == 0);
         if (phase_entries == 10) begin
            settle_block();
            write_limit(pick_limit());
            phase_entries = 0;
         end
         build_random_entry();
         send_entry();
         phase_entries++;
      end

      settle_block();
      repeat (16) @(posedge clock);
      $display("covered %0d entries, %0d byte transfers, %0d checked results, %0d limit writes",
               entries_sent, transfers_sent, results_checked, limit_writes);
      $display("limits 1 and 2^24 both set; good, cut, padded and broken entries mixed");
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("** lz10_stream_decompressor_unit: PASSED **");
      end else begin
         $display("** lz10_stream_decompressor_unit: FAILED **");
      end
      $finish;
   end

endmodule
